// File: src/ptt_pkg.sv
// Package for the periodic task timer table: command and status codes, beat
// types for both channels, table entry layout and controller/datapath structs.
// Depends on nothing; every other file of the block refers to it by scope.
package ptt_pkg;

  // Largest number of result beats one dispatch may produce.
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned RES_W       = $clog2(MAX_RESULTS);

  // Pending run counts saturate at this value.
  localparam logic [7:0] PEND_MAX = 8'hFF;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_DISP = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_DELETED   = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_TICK_DONE = 3'd4,
    ST_DUE       = 3'd5,
    ST_NONE_DUE  = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ONE,
    S_TICK,
    S_FIND,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  slot_select;
    logic [15:0] delay_ticks;
    logic [15:0] period_ticks;
  } in_beat_t;

  typedef struct packed {
    logic [3:0] slot;
    logic [2:0] status;
    logic [7:0] runs_left;
    logic       last_of_run;
  } out_beat_t;

  // One row of the timer table memory.
  typedef struct packed {
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  pending;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic tick_step;
    logic find;
    logic emit;
    logic one_push;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic any_pending;
    logic tick_done;
    logic last;
  } sts_t;

endpackage

// File: src/ptt_ctrl.sv
// Controller of the periodic task timer table: sequences add, delete, tick
// and dispatch. Depends on ptt_pkg; drives ptt_dp through ctl_t and sts_t.
module ptt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    in_command_i,
  output logic          in_ready_o,
  input  ptt_pkg::sts_t sts_i,
  output ptt_pkg::ctl_t ctl_o
);

  ptt_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    ctl_o      = '0;
    unique case (state_q)
      ptt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load_in = 1'b1;
          unique case (ptt_pkg::cmd_e'(in_command_i))
            ptt_pkg::CMD_ADD:  state_d = ptt_pkg::S_ONE;
            ptt_pkg::CMD_DEL:  state_d = ptt_pkg::S_ONE;
            ptt_pkg::CMD_TICK: state_d = ptt_pkg::S_TICK;
            ptt_pkg::CMD_DISP: begin
              state_d = sts_i.any_pending ? ptt_pkg::S_FIND : ptt_pkg::S_ONE;
            end
          endcase
        end
      end
      ptt_pkg::S_ONE: begin
        if (sts_i.out_free) begin
          ctl_o.one_push = 1'b1;
          state_d        = ptt_pkg::S_IDLE;
        end
      end
      ptt_pkg::S_TICK: begin
        if (sts_i.tick_done) begin
          state_d = ptt_pkg::S_ONE;
        end else begin
          ctl_o.tick_step = 1'b1;
        end
      end
      ptt_pkg::S_FIND: begin
        ctl_o.find = 1'b1;
        state_d    = ptt_pkg::S_EMIT;
      end
      ptt_pkg::S_EMIT: begin
        if (sts_i.out_free) begin
          ctl_o.emit = 1'b1;
          state_d    = sts_i.last ? ptt_pkg::S_IDLE : ptt_pkg::S_FIND;
        end
      end
      default: begin
        state_d = ptt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: src/ptt_dp.sv
// Datapath of the periodic task timer table: the table memory, valid and
// pending flags, walk counters and the output register. Depends on ptt_pkg.
module ptt_dp #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptt_pkg::in_beat_t in_data_i,
  input  ptt_pkg::ctl_t     ctl_i,
  output ptt_pkg::sts_t     sts_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output ptt_pkg::out_beat_t out_data_o
);

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TABLE_SLOTS);
  localparam logic [ptt_pkg::RES_W-1:0] LAST_N = ptt_pkg::RES_W'(ptt_pkg::MAX_RESULTS - 1);

  ptt_pkg::entry_t    mem [TABLE_SLOTS];
  ptt_pkg::entry_t    rd_q;
  ptt_pkg::in_beat_t  in_q;
  ptt_pkg::out_beat_t out_q;
  logic                       out_valid_q;
  logic [TABLE_SLOTS-1:0]     valid_q;
  logic [TABLE_SLOTS-1:0]     pnz_q;
  logic [CNT_W-1:0]           ptr_q;
  logic                       tv_q;
  logic [IDX_W-1:0]           taddr_q;
  logic [IDX_W-1:0]           cur_q;
  logic [ptt_pkg::RES_W-1:0]  n_q;

  logic                       full;
  logic [IDX_W-1:0]           free_idx;
  logic                       sel_ok;
  logic                       sel_hit;
  logic [IDX_W-1:0]           sel_idx;
  logic [IDX_W-1:0]           cand;
  logic                       more_due;
  logic                       ptr_in;
  logic                       tick_wb;
  logic                       one_shot;
  logic [7:0]                 dec;
  logic                       add_ok;
  logic                       del_ok;
  ptt_pkg::entry_t            tick_upd;
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;
  ptt_pkg::entry_t            wr_data;
  logic                       rd_en;
  logic [IDX_W-1:0]           rd_addr;
  ptt_pkg::out_beat_t         res;

  // Lowest free slot for an add.
  always_comb begin
    free_idx = '0;
    for (int j = TABLE_SLOTS - 1; j >= 0; j--) begin
      if (!valid_q[j]) begin
        free_idx = IDX_W'(j);
      end
    end
  end
  assign full = &valid_q;

  // Delete target check.
  assign sel_ok  = (int'(in_q.slot_select) < TABLE_SLOTS);
  assign sel_idx = IDX_W'(in_q.slot_select);
  assign sel_hit = sel_ok && valid_q[sel_idx];

  // Next slot with pending runs at or above the walk pointer, and whether
  // any slot above the current one still has runs pending.
  always_comb begin
    cand     = '0;
    more_due = 1'b0;
    for (int j = TABLE_SLOTS - 1; j >= 0; j--) begin
      if (pnz_q[j] && (j >= int'(ptr_q))) begin
        cand = IDX_W'(j);
      end
      if (pnz_q[j] && (j > int'(cur_q))) begin
        more_due = 1'b1;
      end
    end
  end

  assign ptr_in = (ptr_q < SLOTS_CNT);

  // Tick update of the entry held in the read register.
  always_comb begin
    tick_upd = rd_q;
    if (rd_q.delay == 16'd0) begin
      if (rd_q.pending != ptt_pkg::PEND_MAX) begin
        tick_upd.pending = rd_q.pending + 8'd1;
      end
      if (rd_q.period != 16'd0) begin
        tick_upd.delay = rd_q.period;
      end
    end else begin
      tick_upd.delay = rd_q.delay - 16'd1;
    end
  end
  assign tick_wb = ctl_i.tick_step && tv_q && valid_q[taddr_q];

  // Dispatch of the entry held in the read register.
  assign one_shot = (rd_q.period == 16'd0);
  assign dec      = rd_q.pending - 8'd1;

  assign add_ok = ctl_i.one_push && (ptt_pkg::cmd_e'(in_q.command) == ptt_pkg::CMD_ADD) && !full;
  assign del_ok = ctl_i.one_push && (ptt_pkg::cmd_e'(in_q.command) == ptt_pkg::CMD_DEL) && sel_hit;

  // Memory port selection: one write and one read a cycle.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (add_ok) begin
      wr_en   = 1'b1;
      wr_addr = free_idx;
      wr_data = '{delay: in_q.delay_ticks, period: in_q.period_ticks, pending: 8'd0};
    end else if (tick_wb) begin
      wr_en   = 1'b1;
      wr_addr = taddr_q;
      wr_data = tick_upd;
    end else if (ctl_i.emit && !one_shot) begin
      wr_en   = 1'b1;
      wr_addr = cur_q;
      wr_data = '{delay: rd_q.delay, period: rd_q.period, pending: dec};
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (ctl_i.tick_step && ptr_in) begin
      rd_en   = 1'b1;
      rd_addr = ptr_q[IDX_W-1:0];
    end else if (ctl_i.find) begin
      rd_en   = 1'b1;
      rd_addr = cand;
    end
  end

  // Table memory with registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Result beat assembly.
  always_comb begin
    res = '{slot: 4'd0, status: ptt_pkg::ST_NONE_DUE, runs_left: 8'd0, last_of_run: 1'b1};
    if (ctl_i.emit) begin
      res.slot        = 4'(cur_q);
      res.status      = ptt_pkg::ST_DUE;
      res.runs_left   = one_shot ? 8'd0 : dec;
      res.last_of_run = !more_due || (n_q == LAST_N);
    end else begin
      unique case (ptt_pkg::cmd_e'(in_q.command))
        ptt_pkg::CMD_ADD: begin
          if (full) begin
            res.status = ptt_pkg::ST_FULL;
          end else begin
            res.slot   = 4'(free_idx);
            res.status = ptt_pkg::ST_ADDED;
          end
        end
        ptt_pkg::CMD_DEL: begin
          res.slot   = in_q.slot_select;
          res.status = sel_hit ? ptt_pkg::ST_DELETED : ptt_pkg::ST_EMPTY;
        end
        ptt_pkg::CMD_TICK: res.status = ptt_pkg::ST_TICK_DONE;
        ptt_pkg::CMD_DISP: res.status = ptt_pkg::ST_NONE_DUE;
      endcase
    end
  end

  // Captured command beat.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_in) begin
      in_q <= in_data_i;
    end
  end

  // Valid and pending flags of every slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      pnz_q   <= '0;
    end else begin
      if (add_ok) begin
        valid_q[free_idx] <= 1'b1;
        pnz_q[free_idx]   <= 1'b0;
      end
      if (del_ok) begin
        valid_q[sel_idx] <= 1'b0;
        pnz_q[sel_idx]   <= 1'b0;
      end
      if (tick_wb && (rd_q.delay == 16'd0)) begin
        pnz_q[taddr_q] <= 1'b1;
      end
      if (ctl_i.emit) begin
        if (one_shot) begin
          valid_q[cur_q] <= 1'b0;
          pnz_q[cur_q]   <= 1'b0;
        end else begin
          pnz_q[cur_q] <= (dec != 8'd0);
        end
      end
    end
  end

  // Walk pointer, read stage flag and result counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      tv_q  <= 1'b0;
      n_q   <= '0;
    end else if (ctl_i.load_in) begin
      ptr_q <= '0;
      tv_q  <= 1'b0;
      n_q   <= '0;
    end else if (ctl_i.tick_step) begin
      tv_q <= ptr_in;
      if (ptr_in) begin
        ptr_q <= ptr_q + CNT_W'(1);
      end
    end else if (ctl_i.emit) begin
      ptr_q <= CNT_W'(cur_q) + CNT_W'(1);
      n_q   <= n_q + ptt_pkg::RES_W'(1);
    end
  end

  // Slot addresses that travel with the read data.
  always_ff @(posedge clk_i) begin
    if (ctl_i.tick_step) begin
      taddr_q <= ptr_q[IDX_W-1:0];
    end
    if (ctl_i.find) begin
      cur_q <= cand;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.one_push || ctl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.one_push || ctl_i.emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.out_free    = !out_valid_q || out_ready_i;
  assign sts_o.any_pending = |pnz_q;
  assign sts_o.tick_done   = (ptr_q == SLOTS_CNT) && !tv_q;
  assign sts_o.last        = !more_due || (n_q == LAST_N);

endmodule

// File: src/periodic_task_timer_table.sv
// Top level of the periodic task timer table: controller plus datapath.
// Depends on ptt_pkg, ptt_ctrl and ptt_dp.
//
//   channel | direction | handshake                | beat type
//   in      | input     | in_valid_i / in_ready_o  | ptt_pkg::in_beat_t
//   out     | output    | out_valid_o / out_ready_i| ptt_pkg::out_beat_t
//
// Add, delete and an empty dispatch go from accept through S_ONE to the output register.
// A tick walks the table memory one slot a cycle through its registered read.
// A dispatch handles each due slot in S_FIND (find and read), then S_EMIT (update).
// One command is worked on at a time; a new beat is taken once the last
// result sits in the output register. A stalled output holds the dispatch
// walk and the final result of every command.
// Reset clears all valid and pending flags; the memory needs no clearing.
module periodic_task_timer_table #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ptt_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ptt_pkg::out_beat_t out_data_o
);

  ptt_pkg::ctl_t ctl;
  ptt_pkg::sts_t sts;

  ptt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_data_i.command),
    .in_ready_o   (in_ready_o),
    .sts_i        (sts),
    .ctl_o        (ctl)
  );

  ptt_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // A result is only pushed when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.one_push || ctl.emit) |-> sts.out_free)
    else $error("result pushed into a full output register");

  // At most one datapath command is issued in any cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl.load_in, ctl.tick_step, ctl.find, ctl.emit, ctl.one_push}))
    else $error("conflicting datapath commands");

  // The final result of a command returns the block to accepting beats.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.one_push || (ctl.emit && sts.last)) |=> in_ready_o)
    else $error("block not ready after final result");

  // Every pushed result appears at the output in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.one_push || ctl.emit) |=> out_valid_o)
    else $error("pushed result not presented");

endmodule
